// ===== sv/stack_queue_engine_defines.svh =====
// Assertion macros for the stack queue engine port-level checker.
`ifndef STACK_QUEUE_ENGINE_DEFINES_SVH
`define STACK_QUEUE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define SQE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sqe check failed: same-cycle implication");

// Next-cycle implication, disabled while rst is high.
`define SQE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sqe check failed: next-cycle implication");

`endif

// ===== sv/sqe_pkg.sv =====
// Package with the types, codes and helpers of the stack queue engine.
`default_nettype none
package sqe_pkg;

   // Store geometry
   localparam int DEPTH = 64;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   // Command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   // Input opcodes
   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_DUMP = 3'd1,
      OP_PEEK = 3'd2,
      OP_POP  = 3'd3,
      OP_SWAP = 3'd4
   } sqe_opcode_type;

   // Result status codes
   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_BADARG    = 3'd1,
      STAT_PEEKEMPTY = 3'd2,
      STAT_POPEMPTY  = 3'd3,
      STAT_SWAPSHORT = 3'd4,
      STAT_FULL      = 3'd5
   } sqe_status_type;

   // Classified command kinds
   typedef enum logic [2:0] {
      CMD_PUSH,
      CMD_BADARG,
      CMD_DUMP,
      CMD_PEEK,
      CMD_POP,
      CMD_SWAP
   } sqe_kind_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SWAP_B,
      S_SWAP_WA,
      S_SWAP_WB
   } sqe_state_type;

   typedef struct packed {
      sqe_kind_type kind;
      logic [31:0]  value;
   } sqe_cmd_type;

   typedef struct packed {
      logic [31:0]    value;
      logic           rvalid;
      sqe_status_type status;
      logic           last;
   } sqe_rsp_type;

   // Circular position base + off, with base < DEPTH and off <= DEPTH
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + (AW+1)'(off);
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== sv/sqe_front.sv =====
// Front end: accepts request items, classifies them and queues commands.
`default_nettype none
module sqe_front (
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [31:0]         req_tdata,   // push_value[31:0]
   input  wire logic [3:0]          req_tuser,   // opcode[2:0], value_valid[3]
   input  wire logic                q_full,
   output logic                     q_wr,
   output sqe_pkg::sqe_cmd_type     q_wdata
);
   import sqe_pkg::*;

   logic keep;

   assign req_tready = !q_full;

   // Decode opcode; unused codes are accepted and dropped
   always_comb begin
      keep          = 1'b1;
      q_wdata.value = req_tdata;
      q_wdata.kind  = CMD_PUSH;
      unique case (req_tuser[2:0])
         OP_PUSH: q_wdata.kind = req_tuser[3] ? CMD_PUSH : CMD_BADARG;
         OP_DUMP: q_wdata.kind = CMD_DUMP;
         OP_PEEK: q_wdata.kind = CMD_PEEK;
         OP_POP:  q_wdata.kind = CMD_POP;
         OP_SWAP: q_wdata.kind = CMD_SWAP;
         default: keep = 1'b0;
      endcase
   end

   assign q_wr = req_tvalid && req_tready && keep;

endmodule
`default_nettype wire

// ===== sv/sqe_queue.sv =====
// Short command queue between the front and back ends.
`default_nettype none
module sqe_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr,
   input  wire sqe_pkg::sqe_cmd_type wdata,
   output logic                     full,
   input  wire logic                rd,
   output logic                     valid,
   output sqe_pkg::sqe_cmd_type     rdata
);
   import sqe_pkg::*;

   sqe_cmd_type    slot_ff [QDEPTH];
   logic [QAW-1:0] wptr_ff, wptr_in;
   logic [QAW-1:0] rptr_ff, rptr_in;
   logic [QCW-1:0] cnt_ff, cnt_in;
   logic           do_wr, do_rd;

   assign full  = (cnt_ff == QCW'(QDEPTH));
   assign valid = (cnt_ff != '0);
   assign rdata = slot_ff[rptr_ff];
   assign do_wr = wr && !full;
   assign do_rd = rd && valid;

   // Pointer and fill-count update
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == QAW'(QDEPTH - 1)) ? '0 : wptr_ff + QAW'(1);
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == QAW'(QDEPTH - 1)) ? '0 : rptr_ff + QAW'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + QCW'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Payload slots
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

// ===== sv/sqe_back.sv =====
// Back end: entry store, top/count bookkeeping and result sequencing.
`default_nettype none
module sqe_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_at_top,
   input  wire logic                 cmd_valid,
   input  wire sqe_pkg::sqe_cmd_type cmd,
   output logic                      cmd_take,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sqe_pkg::sqe_rsp_type      rsp
);
   import sqe_pkg::*;

   // Entry store
   logic [31:0]   mem [DEPTH];
   logic [31:0]   rdata_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [31:0]   mem_wdata;

   sqe_state_type state_ff, state_in;
   logic [AW-1:0] top_ff, top_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] k_ff, k_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic [31:0]   hold_ff, hold_in;
   logic          rsp_valid_ff;
   sqe_rsp_type   rsp_ff;

   logic          slot_free, emit_en, is_last;
   sqe_rsp_type   emit;
   logic [CW-1:0] k_nx;
   logic [AW-1:0] second_pos, push_pos;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign k_nx       = CW'(k_ff) + CW'(1);
   assign is_last    = (k_nx == lim_ff);
   assign second_pos = wrap_add(top_ff, CW'(1));
   assign push_pos   = push_at_top ? wrap_add(top_ff, CW'(DEPTH - 1))
                                   : wrap_add(top_ff, count_ff);

   // Sequencer: next state, store access and result
   always_comb begin
      state_in  = state_ff;
      top_in    = top_ff;
      count_in  = count_ff;
      k_in      = k_ff;
      lim_in    = lim_ff;
      hold_in   = hold_ff;
      mem_we    = 1'b0;
      mem_waddr = push_pos;
      mem_wdata = cmd.value;
      mem_re    = 1'b0;
      mem_raddr = top_ff;
      emit_en   = 1'b0;
      emit      = '{value: '0, rvalid: 1'b0, status: STAT_OK, last: 1'b1};
      cmd_take  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  CMD_PUSH: begin
                     if (slot_free) begin
                        cmd_take = 1'b1;
                        emit_en  = 1'b1;
                        if (count_ff == CW'(DEPTH)) begin
                           emit.status = STAT_FULL;
                        end else begin
                           mem_we   = 1'b1;
                           count_in = count_ff + CW'(1);
                           if (push_at_top) begin
                              top_in = push_pos;
                           end
                        end
                     end
                  end
                  CMD_BADARG: begin
                     if (slot_free) begin
                        cmd_take    = 1'b1;
                        emit_en     = 1'b1;
                        emit.status = STAT_BADARG;
                     end
                  end
                  CMD_POP: begin
                     if (slot_free) begin
                        cmd_take = 1'b1;
                        emit_en  = 1'b1;
                        if (count_ff == '0) begin
                           emit.status = STAT_POPEMPTY;
                        end else begin
                           top_in   = second_pos;
                           count_in = count_ff - CW'(1);
                        end
                     end
                  end
                  CMD_PEEK: begin
                     if (count_ff == '0) begin
                        if (slot_free) begin
                           cmd_take    = 1'b1;
                           emit_en     = 1'b1;
                           emit.status = STAT_PEEKEMPTY;
                        end
                     end else begin
                        cmd_take = 1'b1;
                        mem_re   = 1'b1;
                        k_in     = '0;
                        lim_in   = CW'(1);
                        state_in = S_READ;
                     end
                  end
                  CMD_DUMP: begin
                     // empty dump gives no result at all
                     cmd_take = 1'b1;
                     if (count_ff != '0) begin
                        mem_re   = 1'b1;
                        k_in     = '0;
                        lim_in   = count_ff;
                        state_in = S_READ;
                     end
                  end
                  CMD_SWAP: begin
                     if (count_ff < CW'(2)) begin
                        if (slot_free) begin
                           cmd_take    = 1'b1;
                           emit_en     = 1'b1;
                           emit.status = STAT_SWAPSHORT;
                        end
                     end else begin
                        cmd_take = 1'b1;
                        mem_re   = 1'b1;
                        state_in = S_SWAP_B;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            // emit current entry, fetch the next one in the same cycle
            if (slot_free) begin
               emit_en     = 1'b1;
               emit.value  = rdata_ff;
               emit.rvalid = 1'b1;
               emit.last   = is_last;
               if (is_last) begin
                  state_in = S_IDLE;
               end else begin
                  k_in      = k_nx[AW-1:0];
                  mem_re    = 1'b1;
                  mem_raddr = wrap_add(top_ff, k_nx);
               end
            end
         end
         S_SWAP_B: begin
            hold_in   = rdata_ff;
            mem_re    = 1'b1;
            mem_raddr = second_pos;
            state_in  = S_SWAP_WA;
         end
         S_SWAP_WA: begin
            mem_we    = 1'b1;
            mem_waddr = top_ff;
            mem_wdata = rdata_ff;
            state_in  = S_SWAP_WB;
         end
         S_SWAP_WB: begin
            // rewrite is harmless while the result slot is busy
            mem_we    = 1'b1;
            mem_waddr = second_pos;
            mem_wdata = hold_ff;
            if (slot_free) begin
               emit_en  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
         count_ff <= count_in;
         if (emit_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      lim_ff  <= lim_in;
      hold_ff <= hold_in;
      if (emit_en) begin
         rsp_ff <= emit;
      end
   end

   // Store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

// ===== sv/stack_queue_engine.sv =====
// Top level of the stack queue engine: front end, command queue, back end.
//
//   channel  dir  payload
//   req_     in   tdata push_value, tuser opcode and value_valid
//   rsp_     out  tdata read_value, tuser read_valid and status, tlast last
//   csr_     in   csr_wdata push_at_top, written when csr_we is high
//
// Push, pop, bad push and failed commands finish in S_IDLE of the back end.
// Peek goes on to S_READ, swap to S_SWAP_B, S_SWAP_WA and S_SWAP_WB, and dump
// stays in S_READ entry by entry, as the entry store has a single read port.
// A two-command queue lets requests be taken while the back end is busy,
// and a registered result slot holds a result while rsp_tready is low.
// Reset is synchronous; store contents stay undefined until written.
`default_nettype none
module stack_queue_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // push_value[31:0]
   input  wire logic [3:0]  req_tuser,   // opcode[2:0], value_valid[3]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // read_value[31:0]
   output logic [3:0]       rsp_tuser,   // read_valid[0], status[3:1]
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic        csr_wdata
);
   import sqe_pkg::*;

   logic        push_at_top_ff;
   logic        q_wr, q_full, q_valid, q_rd;
   sqe_cmd_type q_wdata, q_rdata;
   sqe_rsp_type rsp;

   // Mode register, stack mode after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         push_at_top_ff <= 1'b1;
      end else if (csr_we) begin
         push_at_top_ff <= csr_wdata;
      end
   end

   sqe_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_wr       (q_wr),
      .q_wdata    (q_wdata)
   );

   sqe_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .wdata (q_wdata),
      .full  (q_full),
      .rd    (q_rd),
      .valid (q_valid),
      .rdata (q_rdata)
   );

   sqe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .push_at_top (push_at_top_ff),
      .cmd_valid   (q_valid),
      .cmd         (q_rdata),
      .cmd_take    (q_rd),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   assign rsp_tdata = rsp.value;
   assign rsp_tuser = {rsp.status, rsp.rvalid};
   assign rsp_tlast = rsp.last;

endmodule
`default_nettype wire

// ===== sv/sqe_checker.sv =====
// Port-level checker for the stack queue engine, bound to the top level.
`default_nettype none
`include "stack_queue_engine_defines.svh"
module sqe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [3:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import sqe_pkg::*;

   // No result is pending right after reset
   `SQE_ASSERT_NXT(a_reset_clears, clock, 1'b0, reset, !rsp_tvalid)

   // A stalled result stays put
   `SQE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // An entry read always carries ok status
   `SQE_ASSERT_IMP(a_read_ok, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tuser[3:1] == STAT_OK)

   // Status-only results are single, zero-valued and never a bad code
   `SQE_ASSERT_IMP(a_status_only, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tlast && rsp_tdata == 32'd0 && rsp_tuser[3:1] <= STAT_FULL)

endmodule

bind stack_queue_engine sqe_checker u_sqe_checker (.*);
`default_nettype wire

// ===== tb/sv/sqe_deque_checker.sv =====
// Checker for the stack queue engine: tracks the deque and compares every result item.
module sqe_deque_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,   // push_value[31:0]
   input  wire logic [3:0]  req_tuser,   // opcode[2:0], value_valid[3]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,   // read_value[31:0]
   input  wire logic [3:0]  rsp_tuser,   // read_valid[0], status[3:1]
   input  wire logic        rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic        csr_wdata,
   output int               errors,
   output int               outstanding,
   output int               results_checked
);
   import sqe_pkg::*;

   // Shadow of the deque: circular store, top position, occupancy, push mode
   logic [31:0] deque_mem [DEPTH];
   int          head_pos;
   int          fill_level;
   logic        push_on_top;

   sqe_rsp_type pending_rsp [$];

   function automatic sqe_rsp_type make_rsp(input logic [31:0] value, input logic rvalid,
                                            input sqe_status_type st, input logic last);
      sqe_rsp_type r;
      r.value  = value;
      r.rvalid = rvalid;
      r.status = st;
      r.last   = last;
      return r;
   endfunction

   // Update the shadow deque for one accepted command and queue its result items
   task automatic apply_command(input logic [2:0] op, input logic [31:0] value,
                                input logic value_ok);
      int          idx;
      logic [31:0] tmp;
      case (op)
         OP_PUSH: begin
            if (!value_ok) begin
               pending_rsp.push_back(make_rsp('0, 1'b0, STAT_BADARG, 1'b1));
            end else if (fill_level >= DEPTH) begin
               pending_rsp.push_back(make_rsp('0, 1'b0, STAT_FULL, 1'b1));
            end else begin
               if (push_on_top) begin
                  head_pos = (head_pos + DEPTH - 1) % DEPTH;
                  deque_mem[head_pos] = value;
               end else begin
                  deque_mem[(head_pos + fill_level) % DEPTH] = value;
               end
               fill_level++;
               pending_rsp.push_back(make_rsp('0, 1'b0, STAT_OK, 1'b1));
            end
         end
         OP_DUMP: begin
            // top to bottom; an empty deque gives nothing
            for (int k = 0; k < fill_level; k++) begin
               idx = (head_pos + k) % DEPTH;
               pending_rsp.push_back(make_rsp(deque_mem[idx], 1'b1, STAT_OK,
                                              k == fill_level - 1));
            end
         end
         OP_PEEK: begin
            if (fill_level == 0) begin
               pending_rsp.push_back(make_rsp('0, 1'b0, STAT_PEEKEMPTY, 1'b1));
            end else begin
               pending_rsp.push_back(make_rsp(deque_mem[head_pos], 1'b1, STAT_OK, 1'b1));
            end
         end
         OP_POP: begin
            if (fill_level == 0) begin
               pending_rsp.push_back(make_rsp('0, 1'b0, STAT_POPEMPTY, 1'b1));
            end else begin
               head_pos = (head_pos + 1) % DEPTH;
               fill_level--;
               pending_rsp.push_back(make_rsp('0, 1'b0, STAT_OK, 1'b1));
            end
         end
         OP_SWAP: begin
            if (fill_level < 2) begin
               pending_rsp.push_back(make_rsp('0, 1'b0, STAT_SWAPSHORT, 1'b1));
            end else begin
               idx = (head_pos + 1) % DEPTH;
               tmp = deque_mem[head_pos];
               deque_mem[head_pos] = deque_mem[idx];
               deque_mem[idx] = tmp;
               pending_rsp.push_back(make_rsp('0, 1'b0, STAT_OK, 1'b1));
            end
         end
         default: begin
            // spare opcodes are dropped without a result
         end
      endcase
   endtask

   // Compare one result item against the oldest expectation
   task automatic check_result();
      sqe_rsp_type want;
      if (pending_rsp.size() == 0) begin
         $display("%0t sqe_checker: unexpected item, actual value %h tuser %h last %b",
                  $time, rsp_tdata, rsp_tuser, rsp_tlast);
         errors++;
         return;
      end
      want = pending_rsp.pop_front();
      results_checked++;
      if (rsp_tdata !== want.value) begin
         $display("%0t sqe_checker: read_value expected %h actual %h",
                  $time, want.value, rsp_tdata);
         errors++;
      end
      if (rsp_tuser[0] !== want.rvalid) begin
         $display("%0t sqe_checker: read_valid expected %b actual %b",
                  $time, want.rvalid, rsp_tuser[0]);
         errors++;
      end
      if (rsp_tuser[3:1] !== want.status) begin
         $display("%0t sqe_checker: status expected %0d actual %0d",
                  $time, want.status, rsp_tuser[3:1]);
         errors++;
      end
      if (rsp_tlast !== want.last) begin
         $display("%0t sqe_checker: last expected %b actual %b",
                  $time, want.last, rsp_tlast);
         errors++;
      end
   endtask

   // Sample both channels and the mode register at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         head_pos = 0;
         fill_level = 0;
         push_on_top = 1'b1;
         pending_rsp.delete();
         errors = 0;
         results_checked = 0;
      end else begin
         if (csr_we) begin
            push_on_top = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            apply_command(req_tuser[2:0], req_tdata, req_tuser[3]);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
      end
      outstanding = pending_rsp.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the stack queue engine: clock, reset, stimulus and verdict.
module tb_top;
   import sqe_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 2 * DEPTH + 16;
   localparam int OVERRUN       = DEPTH + 2;   // enough to hit full or empty from any level
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // push_value[31:0]
   logic [3:0]  req_tuser;    // opcode[2:0], value_valid[3]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // read_value[31:0]
   logic [3:0]  rsp_tuser;    // read_valid[0], status[3:1]
   logic        rsp_tlast;
   logic        csr_we;
   logic        csr_wdata;

   int check_errors;
   int outstanding;
   int results_checked;
   int items_sent = 0;
   int mode_writes = 0;
   int cycles = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   always #6 clock = ~clock;

   stack_queue_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   sqe_deque_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .errors          (check_errors),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   // Result side backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Push values lean toward the corners of the signed range
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 32'h8000_0000;
      if (r < 20) return 32'h7fff_ffff;
      if (r < 25) return 32'h0000_0000;
      if (r < 30) return 32'hffff_ffff;
      return $urandom;
   endfunction

   // Offer one item, with random gaps first, and wait for the handshake
   task automatic send_cmd(input logic [2:0] op, input logic [31:0] value,
                           input logic value_ok);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= {value_ok, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Wait until every expected item is back, then let the engine go quiet
   task automatic settle(input int quiet_cycles);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (quiet_cycles) @(posedge clock);
   endtask

   task automatic set_mode(input logic at_top);
      settle(SETTLE_CYCLES);
      csr_we    <= 1'b1;
      csr_wdata <= at_top;
      @(posedge clock);
      csr_we    <= 1'b0;
      mode_writes++;
   endtask

   // Commands that leave the occupancy alone
   task automatic send_side_cmd();
      case ($urandom_range(0, 3))
         0:       send_cmd(OP_PEEK, $urandom, 1'($urandom_range(0, 1)));
         1:       send_cmd(OP_SWAP, $urandom, 1'($urandom_range(0, 1)));
         2:       send_cmd(OP_DUMP, $urandom, 1'($urandom_range(0, 1)));
         default: send_cmd(OP_PUSH, $urandom, 1'b0);
      endcase
   endtask

   task automatic send_random_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)      send_cmd(OP_PUSH, pick_value(), 1'b1);
      else if (r < 45) send_cmd(OP_PUSH, $urandom, 1'b0);
      else if (r < 53) send_cmd(OP_DUMP, $urandom, 1'($urandom_range(0, 1)));
      else if (r < 65) send_cmd(OP_PEEK, $urandom, 1'($urandom_range(0, 1)));
      else if (r < 85) send_cmd(OP_POP, $urandom, 1'($urandom_range(0, 1)));
      else if (r < 97) send_cmd(OP_SWAP, $urandom, 1'($urandom_range(0, 1)));
      else send_cmd(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom,
                    1'($urandom_range(0, 1)));
   endtask

   // Push until the store must have overflowed
   task automatic fill_store();
      int pushes;
      pushes = 0;
      while (pushes < OVERRUN) begin
         if ($urandom_range(0, 99) < 90) begin
            send_cmd(OP_PUSH, pick_value(), 1'b1);
            pushes++;
         end else begin
            send_side_cmd();
         end
      end
   endtask

   // Pop until the store must have run dry, with a few pushes mixed in
   task automatic drain_store();
      int net_pops;
      int r;
      net_pops = 0;
      while (net_pops < OVERRUN) begin
         r = $urandom_range(0, 99);
         if (r < 85) begin
            send_cmd(OP_POP, $urandom, 1'($urandom_range(0, 1)));
            net_pops++;
         end else if (r < 88) begin
            send_cmd(OP_PUSH, pick_value(), 1'b1);
            net_pops--;
         end else begin
            send_side_cmd();
         end
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_we     <= 1'b0;
      csr_wdata  <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-store failures, corner values, every opcode, spare codes
      set_mode(1'b1);
      send_cmd(OP_PEEK, 32'h0, 1'b0);
      send_cmd(OP_POP, 32'h0, 1'b0);
      send_cmd(OP_SWAP, 32'h0, 1'b0);
      send_cmd(OP_DUMP, 32'h0, 1'b0);
      send_cmd(OP_PUSH, 32'hffff_ffff, 1'b0);
      send_cmd(OP_PUSH, 32'h8000_0000, 1'b1);
      send_cmd(OP_SWAP, 32'hffff_ffff, 1'b1);
      send_cmd(OP_DUMP, 32'h0, 1'b1);
      send_cmd(OP_PUSH, 32'h7fff_ffff, 1'b1);
      send_cmd(OP_PUSH, 32'h0000_0000, 1'b1);
      send_cmd(OP_PEEK, 32'h0, 1'b1);
      send_cmd(OP_SWAP, 32'h0, 1'b0);
      send_cmd(OP_DUMP, 32'h0, 1'b0);
      send_cmd(OP_SPARE_LO, 32'hffff_ffff, 1'b1);
      send_cmd(3'(OP_SPARE_LO + 3'd1), 32'h0, 1'b0);
      send_cmd(OP_SPARE_HI, 32'h8000_0000, 1'b1);
      send_cmd(OP_POP, 32'h0, 1'b0);
      send_cmd(OP_PEEK, 32'h0, 1'b0);
      send_cmd(OP_POP, 32'h0, 1'b1);
      send_cmd(OP_POP, 32'h0, 1'b1);
      send_cmd(OP_DUMP, 32'h0, 1'b1);

      // Random phases: fill in one push mode, drain in the other
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0:       begin tx_idle_pct = 36; rx_idle_pct = 49; end
            1:       begin tx_idle_pct = 49; rx_idle_pct = 36; end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
         endcase
         set_mode(ph == 1);
         repeat (2) send_random_cmd();
         fill_store();
         send_cmd(OP_DUMP, $urandom, 1'($urandom_range(0, 1)));
         set_mode(ph != 1);
         drain_store();
         repeat (2) send_random_cmd();
      end

      settle(DRAIN_CYCLES);
      $display("summary: %0d items sent over %0d push-mode writes, %0d result items checked",
               items_sent, mode_writes, results_checked);
      if (check_errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
